[rtl/scsp_pkg.sv]
`timescale 1ns / 1ps
package scsp_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_COUNT  = 2'd1,
    CMD_PREFIX = 2'd2,
    CMD_PLACE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ERR_OK  = 2'd0,
    ERR_KEY = 2'd1,
    ERR_SAT = 2'd2
  } err_t;

  localparam int KeyW   = 8;
  localparam int ValueW = 16;
  localparam int PosW   = 16;

endpackage

[rtl/scsp_item_if.sv]
`timescale 1ns / 1ps
interface scsp_item_if import scsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic [ValueW-1:0] item_value;
  logic [KeyW-1:0]   item_key;

  modport source (output valid, output cmd, output item_value, output item_key, input ready);
  modport sink   (input valid, input cmd, input item_value, input item_key, output ready);
endinterface

[rtl/scsp_res_if.sv]
`timescale 1ns / 1ps
interface scsp_res_if import scsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PosW-1:0]   position;
  logic [ValueW-1:0] placed_value;
  logic [1:0]        error;

  modport source (output valid, output position, output placed_value, output error,
                  input ready);
  modport sink   (input valid, input position, input placed_value, input error,
                  output ready);
endinterface

[rtl/scsp_cfg_if.sv]
`timescale 1ns / 1ps
interface scsp_cfg_if import scsp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [KeyW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/scsp_ram.sv]
`timescale 1ns / 1ps
module scsp_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data while no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/stable_counting_sort_pass.sv]
`timescale 1ns / 1ps
// Count and place: one counter read, then modify and write back.
// Prefix: counters 0..top, top = min(key_max, NUM_KEYS-1), one per cycle (the last one
// stalls while its saturation result cannot be stored) through the single read and
// single write port of the counter memory. Clear: one counter written per cycle.
// Reset (synchronous): key_max returns to 255, then a clearing sweep of all NUM_KEYS
// counters zeroes the counter memory; no item is taken during the sweep.
module stable_counting_sort_pass
  import scsp_pkg::*;
#(
  parameter int NUM_KEYS  = 256,
  parameter int MAX_ITEMS = 65536
) (
  input logic   clk,
  input logic   rst,
  scsp_item_if.sink   items,
  scsp_res_if.source  results,
  scsp_cfg_if.sink    cfg
);

  localparam int AW = $clog2(NUM_KEYS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int SW = CW + 1;

  localparam logic [CW-1:0]   MAX_C    = CW'(MAX_ITEMS);
  localparam logic [SW-1:0]   MAX_S    = SW'(MAX_ITEMS);
  localparam logic [SW-1:0]   SUM_LIM  = SW'(MAX_ITEMS + 1);
  localparam logic [PosW-1:0] POS_SAT  = PosW'(MAX_ITEMS - 1);
  localparam logic [AW-1:0]   LAST_KEY = AW'(NUM_KEYS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CLEAR,
    S_EXEC,
    S_PREFIX
  } state_t;

  state_t            state;
  logic [AW-1:0]     idx;
  cmd_t              cmd_r;
  logic [ValueW-1:0] val_r;
  logic              key_bad;
  logic [SW-1:0]     sum;
  logic              sat;
  logic [KeyW-1:0]   key_max;

  logic              out_valid;
  logic [PosW-1:0]   out_pos;
  logic [ValueW-1:0] out_val;
  err_t              out_err;

  // memory port signals
  logic              re;
  logic [AW-1:0]     raddr;
  logic [CW-1:0]     rdata;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [CW-1:0]     wdata;

  logic              accept;
  logic              out_free;
  logic [31:0]       key_ext;
  logic [AW-1:0]     key_addr;
  logic              key_ok;
  logic [31:0]       top_ext;
  logic [AW-1:0]     top;
  logic [31:0]       cnt_ext;
  logic              cnt_full;
  logic              ovf;
  logic              last;
  logic [SW-1:0]     sum_add;
  logic [SW-1:0]     sum_next;
  logic              need_res;
  logic              adv;
  logic              load_out;
  logic [PosW-1:0]   res_pos;
  logic [ValueW-1:0] res_val;
  err_t              res_err;

  scsp_ram #(
    .WIDTH (CW),
    .DEPTH (NUM_KEYS)
  ) u_counters (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign items.ready          = (state == S_IDLE);
  assign accept               = items.valid && items.ready;
  assign cfg.ready            = 1'b1;
  assign results.valid        = out_valid;
  assign results.position     = out_pos;
  assign results.placed_value = out_val;
  assign results.error        = out_err;
  assign out_free             = !out_valid || results.ready;

  assign key_ext  = 32'(items.item_key);
  assign key_addr = key_ext[AW-1:0];
  assign key_ok   = (items.item_key <= key_max) && (key_ext < 32'(NUM_KEYS));
  assign top_ext  = (32'(key_max) < 32'(NUM_KEYS - 1)) ? 32'(key_max) : 32'(NUM_KEYS - 1);
  assign top      = top_ext[AW-1:0];

  assign cnt_ext  = 32'(rdata);
  assign cnt_full = (rdata >= MAX_C);
  assign ovf      = (sum > MAX_S);
  assign last     = (idx == top);
  assign sum_add  = sum + SW'(rdata);
  assign sum_next = (sum_add > SUM_LIM) ? SUM_LIM : sum_add;

  always_comb begin
    re       = 1'b0;
    raddr    = key_addr;
    we       = 1'b0;
    waddr    = idx;
    wdata    = '0;
    need_res = 1'b0;
    res_pos  = '0;
    res_val  = '0;
    res_err  = ERR_OK;
    unique case (state)
      S_IDLE: begin
        re    = accept;
        raddr = (cmd_t'(items.cmd) == CMD_PREFIX) ? '0 : key_addr;
      end
      S_CLEAR: begin
        we = 1'b1;
      end
      S_EXEC: begin
        if (key_bad) begin
          need_res = 1'b1;
          res_err  = ERR_KEY;
          res_val  = (cmd_r == CMD_PLACE) ? val_r : '0;
        end else if (cnt_full) begin
          need_res = 1'b1;
          res_err  = ERR_SAT;
          we       = 1'b1;
          wdata    = MAX_C;
          if (cmd_r == CMD_PLACE) begin
            res_pos = POS_SAT;
            res_val = val_r;
          end
        end else begin
          we    = 1'b1;
          wdata = rdata + CW'(1);
          if (cmd_r == CMD_PLACE) begin
            need_res = 1'b1;
            res_pos  = cnt_ext[PosW-1:0];
            res_val  = val_r;
          end
        end
      end
      S_PREFIX: begin
        we       = 1'b1;
        wdata    = ovf ? MAX_C : sum[CW-1:0];
        need_res = last && (sat || ovf);
        res_err  = ERR_SAT;
        re       = !last;
        raddr    = idx + AW'(1);
      end
      default: begin
      end
    endcase
    // stall the step while its result cannot be stored
    adv      = !need_res || out_free;
    load_out = need_res && adv;
    if (!adv) begin
      we = 1'b0;
      re = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      idx       <= '0;
      out_valid <= 1'b0;
      key_max   <= 8'hFF;
    end else begin
      if (cfg.valid && cfg.ready) begin
        key_max <= cfg.data;
      end
      if (results.valid && results.ready) begin
        out_valid <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
        out_pos   <= res_pos;
        out_val   <= res_val;
        out_err   <= res_err;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cmd_r   <= cmd_t'(items.cmd);
            val_r   <= items.item_value;
            key_bad <= !key_ok;
            sum     <= '0;
            sat     <= 1'b0;
            unique case (cmd_t'(items.cmd))
              CMD_CLEAR: begin
                idx   <= '0;
                state <= S_CLEAR;
              end
              CMD_PREFIX: begin
                idx   <= '0;
                state <= S_PREFIX;
              end
              CMD_COUNT, CMD_PLACE: begin
                idx   <= key_addr;
                state <= S_EXEC;
              end
            endcase
          end
        end
        S_CLEAR: begin
          idx <= idx + AW'(1);
          if (idx == LAST_KEY) begin
            state <= S_IDLE;
          end
        end
        S_EXEC: begin
          if (adv) begin
            state <= S_IDLE;
          end
        end
        S_PREFIX: begin
          if (adv) begin
            sum <= sum_next;
            sat <= sat || ovf;
            if (last) begin
              state <= S_IDLE;
            end else begin
              idx <= idx + AW'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_reset_sweep: assert property (@(posedge clk) rst |=> !items.ready)
    else $error("item taken during reset clearing sweep");

  a_prefix_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_PREFIX) |-> (idx <= top))
    else $error("prefix walk beyond covered keys");

  a_counter_bound: assert property (@(posedge clk) disable iff (rst)
    we |-> (wdata <= MAX_C))
    else $error("counter written above item bound");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_EXEC || $past(state) == S_PREFIX))
    else $error("result raised outside count, place or prefix");

  a_exec_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC && !adv) |=> (state == S_EXEC && $stable(rdata)))
    else $error("stalled counter update lost its read data");

endmodule

[tb/tb_stable_counting_sort_pass.sv]
`timescale 1ns / 1ps
module tb_stable_counting_sort_pass;
  import scsp_pkg::*;

  localparam int NUM_KEYS     = 256;
  localparam int MAX_ITEMS    = 65536;
  localparam int DRAIN_CYCLES = 2 * NUM_KEYS + 16;
  localparam int STALL_CYCLES = 400;
  localparam int CYCLE_LIMIT  = 1_500_000;
  localparam int RANDOM_SLICE = 117;

  typedef struct packed {
    logic [PosW-1:0]   position;
    logic [ValueW-1:0] placed_value;
    err_t              error;
  } slot_res_t;

  // One row of the directed script; a config row carries key_max in key.
  typedef struct packed {
    logic              is_cfg;
    cmd_t              cmd;
    logic [ValueW-1:0] value;
    logic [KeyW-1:0]   key;
    logic              typed;
    logic              typed_has;
    slot_res_t         typed_res;
  } step_row_t;

  logic clk;
  logic rst;

  scsp_item_if items_ch ();
  scsp_res_if  results_ch ();
  scsp_cfg_if  cfg_ch ();

  stable_counting_sort_pass #(
    .NUM_KEYS  (NUM_KEYS),
    .MAX_ITEMS (MAX_ITEMS)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch),
    .cfg     (cfg_ch)
  );

  logic [16:0]     key_tally [NUM_KEYS];
  logic [KeyW-1:0] key_limit;
  slot_res_t       pending_slots [$];

  int          src_idle_pct;
  int          snk_idle_pct;
  bit          stall_request;
  int          mismatches;
  int          items_sent;
  int          results_seen;
  int          key_errs;
  int          sat_hits;
  int          sorts_run;
  int          settings_used;
  int          stalls_done;
  int unsigned cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still pending", cycle_count,
               pending_slots.size());
      $display("** stable_counting_sort_pass: FAILED **");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Apply one command to the counter table and work out the result it causes.
  function automatic void advance_counters(input cmd_t c, input logic [ValueW-1:0] v,
                                           input logic [KeyW-1:0] k, output bit has,
                                           output slot_res_t r);
    int unsigned run_sum;
    logic [16:0] held;
    bit          sat;
    int          idx;
    has     = 1'b0;
    r       = '0;
    run_sum = 0;
    sat     = 1'b0;
    case (c)
      CMD_CLEAR: begin
        foreach (key_tally[i]) key_tally[i] = '0;
      end
      CMD_COUNT: begin
        if (k > key_limit) begin
          has     = 1'b1;
          r.error = ERR_KEY;
        end else if (key_tally[k] >= MAX_ITEMS) begin
          key_tally[k] = 17'(MAX_ITEMS);
          has          = 1'b1;
          r.error      = ERR_SAT;
        end else begin
          key_tally[k] = key_tally[k] + 17'd1;
        end
      end
      CMD_PREFIX: begin
        for (idx = 0; idx <= int'(key_limit); idx++) begin
          held = key_tally[idx];
          if (run_sum > MAX_ITEMS) begin
            key_tally[idx] = 17'(MAX_ITEMS);
            sat            = 1'b1;
          end else begin
            key_tally[idx] = run_sum[16:0];
          end
          run_sum += held;
        end
        if (sat) begin
          has     = 1'b1;
          r.error = ERR_SAT;
        end
      end
      default: begin
        has            = 1'b1;
        r.placed_value = v;
        if (k > key_limit) begin
          r.error = ERR_KEY;
        end else if (key_tally[k] >= MAX_ITEMS) begin
          key_tally[k] = 17'(MAX_ITEMS);
          r.position   = PosW'(MAX_ITEMS - 1);
          r.error      = ERR_SAT;
        end else begin
          r.position   = key_tally[k][PosW-1:0];
          r.error      = ERR_OK;
          key_tally[k] = key_tally[k] + 17'd1;
        end
      end
    endcase
  endfunction

  // Present one item, hold it until taken, then update the counter table.
  task automatic offer_item(input cmd_t c, input logic [ValueW-1:0] v,
                            input logic [KeyW-1:0] k, output bit has, output slot_res_t r);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      items_ch.valid <= 1'b0;
      @(posedge clk);
    end
    items_ch.valid      <= 1'b1;
    items_ch.cmd        <= c;
    items_ch.item_value <= v;
    items_ch.item_key   <= k;
    do @(posedge clk); while (!items_ch.ready);
    items_sent++;
    advance_counters(c, v, k, has, r);
  endtask

  task automatic feed(input cmd_t c, input logic [ValueW-1:0] v, input logic [KeyW-1:0] k);
    bit        has;
    slot_res_t r;
    offer_item(c, v, k, has, r);
    if (has) pending_slots.push_back(r);
  endtask

  // Drain, let a clear or prefix walk finish, then write key_max.
  task automatic set_key_max(input logic [KeyW-1:0] v);
    items_ch.valid <= 1'b0;
    while (pending_slots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    key_limit = v;
    settings_used++;
  endtask

  // One radix pass with random content; a few are noise or lack the prefix.
  task automatic run_sort(input bit squeeze);
    logic [KeyW-1:0]   keys [$];
    logic [ValueW-1:0] vals [$];
    logic [KeyW-1:0]   k;
    int                n;
    int                roll;
    roll = $urandom_range(0, 99);
    if (roll < 12 && !squeeze) begin
      repeat ($urandom_range(1, 6))
        feed(cmd_t'($urandom_range(0, 3)), ValueW'($urandom_range(0, 65535)),
             KeyW'($urandom_range(0, 255)));
      return;
    end
    n = squeeze ? 40 : $urandom_range(1, 24);
    feed(CMD_CLEAR, ValueW'($urandom_range(0, 65535)), KeyW'($urandom_range(0, 255)));
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) k = KeyW'($urandom_range(0, 255));
      else k = KeyW'($urandom_range(0, key_limit));
      keys.push_back(k);
      vals.push_back(ValueW'($urandom_range(0, 65535)));
      feed(CMD_COUNT, ValueW'($urandom_range(0, 65535)), k);
    end
    if (roll >= 18 || squeeze)
      feed(CMD_PREFIX, ValueW'($urandom_range(0, 65535)), KeyW'($urandom_range(0, 255)));
    foreach (keys[i]) begin
      feed(CMD_PLACE, vals[i], keys[i]);
      // The prefix walk is over once a place is taken; now starve the output.
      if (squeeze && i == 0) stall_request = 1'b1;
    end
    sorts_run++;
  endtask

  initial begin
    int        stall_left;
    slot_res_t want;
    stall_left = 0;
    results_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (results_ch.valid && results_ch.ready) begin
        results_seen++;
        if (pending_slots.size() == 0) begin
          report_mismatch($sformatf("result pos %0d value %h error %0d with nothing pending",
                                    results_ch.position, results_ch.placed_value,
                                    results_ch.error));
        end else begin
          want = pending_slots.pop_front();
          if (want.error == ERR_KEY) key_errs++;
          if (want.error == ERR_SAT) sat_hits++;
          if (results_ch.position !== want.position)
            report_mismatch($sformatf("position %0d, expected %0d",
                                      results_ch.position, want.position));
          if (results_ch.placed_value !== want.placed_value)
            report_mismatch($sformatf("placed_value %h, expected %h",
                                      results_ch.placed_value, want.placed_value));
          if (results_ch.error !== want.error)
            report_mismatch($sformatf("error %0d, expected %0d",
                                      results_ch.error, want.error));
        end
      end
      if (stall_request) begin
        stall_left    = STALL_CYCLES;
        stall_request = 1'b0;
        stalls_done++;
      end
      if (stall_left > 0) begin
        stall_left--;
        results_ch.ready <= 1'b0;
      end else begin
        results_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
      end
    end
  end

  initial begin
    step_row_t         dir_steps [25];
    step_row_t         row;
    bit                has;
    slot_res_t         got;
    int                mode;
    int                slice;
    int                budget;
    logic [KeyW-1:0]   setting;

    dir_steps = '{
      '{1'b0, CMD_PLACE,  16'h0000, 8'h00, 1'b1, 1'b1, '{16'd0, 16'h0000, ERR_OK}},
      '{1'b0, CMD_PLACE,  16'hFFFF, 8'hFF, 1'b1, 1'b1, '{16'd0, 16'hFFFF, ERR_OK}},
      '{1'b0, CMD_PLACE,  16'h1234, 8'h00, 1'b1, 1'b1, '{16'd1, 16'h1234, ERR_OK}},
      '{1'b0, CMD_CLEAR,  16'hFFFF, 8'hFF, 1'b1, 1'b0, '0},
      '{1'b0, CMD_COUNT,  16'h0000, 8'h05, 1'b0, 1'b0, '0},
      '{1'b0, CMD_COUNT,  16'hFFFF, 8'h05, 1'b0, 1'b0, '0},
      '{1'b0, CMD_COUNT,  16'h0000, 8'h02, 1'b0, 1'b0, '0},
      '{1'b0, CMD_COUNT,  16'h0000, 8'hFF, 1'b0, 1'b0, '0},
      '{1'b0, CMD_PREFIX, 16'h0000, 8'h00, 1'b0, 1'b0, '0},
      '{1'b0, CMD_PLACE,  16'hA5A5, 8'h05, 1'b0, 1'b0, '0},
      '{1'b0, CMD_PLACE,  16'h5A5A, 8'h02, 1'b0, 1'b0, '0},
      '{1'b0, CMD_PLACE,  16'h0001, 8'h05, 1'b0, 1'b0, '0},
      '{1'b0, CMD_PLACE,  16'h8000, 8'hFF, 1'b0, 1'b0, '0},
      '{1'b1, CMD_CLEAR,  16'h0000, 8'd3,  1'b0, 1'b0, '0},
      '{1'b0, CMD_COUNT,  16'h0000, 8'h04, 1'b1, 1'b1, '{16'd0, 16'h0000, ERR_KEY}},
      '{1'b0, CMD_PLACE,  16'h5A5A, 8'hC8, 1'b1, 1'b1, '{16'd0, 16'h5A5A, ERR_KEY}},
      '{1'b0, CMD_COUNT,  16'h0000, 8'h03, 1'b0, 1'b0, '0},
      '{1'b0, CMD_COUNT,  16'h0000, 8'h00, 1'b0, 1'b0, '0},
      '{1'b0, CMD_PREFIX, 16'hFFFF, 8'hFF, 1'b0, 1'b0, '0},
      '{1'b0, CMD_PLACE,  16'hFFFF, 8'h03, 1'b0, 1'b0, '0},
      '{1'b1, CMD_CLEAR,  16'h0000, 8'd0,  1'b0, 1'b0, '0},
      '{1'b0, CMD_COUNT,  16'h0000, 8'h01, 1'b1, 1'b1, '{16'd0, 16'h0000, ERR_KEY}},
      '{1'b0, CMD_PLACE,  16'h00FF, 8'h00, 1'b0, 1'b0, '0},
      '{1'b1, CMD_CLEAR,  16'h0000, 8'd255, 1'b0, 1'b0, '0},
      '{1'b0, CMD_PLACE,  16'h7F7F, 8'h80, 1'b0, 1'b0, '0}
    };

    rst                 <= 1'b1;
    items_ch.valid      <= 1'b0;
    items_ch.cmd        <= CMD_CLEAR;
    items_ch.item_value <= '0;
    items_ch.item_key   <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.data         <= '0;
    foreach (key_tally[i]) key_tally[i] = '0;
    key_limit     = 8'd255;
    stall_request = 1'b0;
    src_idle_pct  = 37;
    snk_idle_pct  = 70;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_steps[i]) begin
      row = dir_steps[i];
      if (row.is_cfg) begin
        set_key_max(row.key);
      end else begin
        offer_item(row.cmd, row.value, row.key, has, got);
        if (row.typed) begin
          if (row.typed_has) pending_slots.push_back(row.typed_res);
        end else if (has) begin
          pending_slots.push_back(got);
        end
      end
    end

    for (mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin
          src_idle_pct = 37;
          snk_idle_pct = 70;
        end
        1: begin
          src_idle_pct = 70;
          snk_idle_pct = 37;
        end
        default: begin
          src_idle_pct = 0;
          snk_idle_pct = 0;
        end
      endcase
      for (slice = 0; slice < 3; slice++) begin
        if (slice == 0) setting = (mode == 1) ? 8'd0 : 8'd255;
        else if (slice == 1 && mode == 0) setting = 8'd1;
        else if ($urandom_range(0, 1) == 0) setting = KeyW'($urandom_range(0, 15));
        else setting = KeyW'($urandom_range(0, 255));
        set_key_max(setting);
        budget = items_sent + RANDOM_SLICE;
        if (mode == 2 && slice == 0) run_sort(1'b1);
        while (items_sent < budget) run_sort(1'b0);
      end
    end

    items_ch.valid <= 1'b0;
    while (pending_slots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d items in %0d random sorts over %0d key_max settings.",
             items_sent, sorts_run, settings_used);
    $display("Checked %0d results: %0d key errors, %0d saturations, %0d output stalls.",
             results_seen, key_errs, sat_hits, stalls_done);
    if (mismatches == 0) begin
      $display("** stable_counting_sort_pass: PASSED **");
    end else begin
      $display("** stable_counting_sort_pass: FAILED **");
    end
    $finish;
  end

endmodule

[stable_counting_sort_pass.f]
rtl/scsp_pkg.sv
rtl/scsp_item_if.sv
rtl/scsp_res_if.sv
rtl/scsp_cfg_if.sv
rtl/scsp_ram.sv
rtl/stable_counting_sort_pass.sv
tb/tb_stable_counting_sort_pass.sv
